[rtl/det_pkg.sv]
// Shared types and constants for the debounced edge timestamper.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package det_pkg;

  // Up to seven bytes per item: a two-byte status reply and a five-byte change frame
  localparam int unsigned MAX_BYTES   = 7;
  localparam int unsigned IDX_W       = $clog2(MAX_BYTES);
  localparam int unsigned CNT_W       = $clog2(MAX_BYTES + 1);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned FRAME_BYTES = 5;

  localparam logic [7:0]  DEBOUNCE_RST  = 8'h05;
  localparam logic [7:0]  STATUS_RQ_RST = 8'h45;  // 'E'
  localparam logic [7:0]  STATUS_RP_RST = 8'h45;  // 'E'
  localparam logic [7:0]  HEADER_RST    = 8'h58;  // 'X'
  localparam logic [7:0]  SCAN_RST      = 8'h4A;  // 'J'
  localparam logic [7:0]  TOP_SAT       = 8'hFF;
  localparam logic [23:0] COUNT_SAT     = 24'hFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TICKS = 3'd0,
    REG_STATUS_RQ      = 3'd1,
    REG_STATUS_RP      = 3'd2,
    REG_HEADER         = 3'd3,
    REG_SCAN           = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_WAIT     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_FRAME    = 2'd2
  } phase_e;

  // One queued job: the bytes caused by one accepted item
  typedef struct packed {
    logic [CNT_W-1:0]              count;
    logic [MAX_BYTES-1:0][7:0]     bytes;
    logic                          led;
  } job_t;

endpackage

`default_nettype wire

[rtl/det_if.sv]
// Handshake channels of the timestamper: input steps, result bytes, register writes.
// Depends on det_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface det_in_if;
  logic       valid;
  logic       ready;
  logic       pin_raw;
  logic       chrono_tick;
  logic       debounce_tick;
  logic       rx_valid;
  logic [7:0] rx_byte;
  modport source (output valid, pin_raw, chrono_tick, debounce_tick, rx_valid, rx_byte,
                  input ready);
  modport sink   (input valid, pin_raw, chrono_tick, debounce_tick, rx_valid, rx_byte,
                  output ready);
endinterface

interface det_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic       led_on;
  modport source (output valid, tx_byte, tx_last, led_on, input ready);
  modport sink   (input valid, tx_byte, tx_last, led_on, output ready);
endinterface

interface det_cfg_if import det_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/det_front.sv]
// Front end: register file, elapsed counter, debounce automaton and job builder.
// Depends on det_pkg and det_if; feeds det_fifo.
`timescale 1ns / 1ps
`default_nettype none

module det_front import det_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  det_in_if.sink    in_i,
  det_cfg_if.sink   cfg_i,
  input  wire logic fifo_full_i,
  output job_t      job_o,
  output logic      push_o
);

  logic [7:0]  deb_ticks_q, status_rq_q, status_rp_q, header_q, scan_q;
  phase_e      phase_q, phase_d;
  logic [23:0] elapsed_q, elapsed_d;
  logic [23:0] stamp_q, stamp_d;
  logic [7:0]  deb_left_q, deb_left_d;
  logic        stable_q, stable_d;
  logic        first_q, first_d;

  logic        accept;
  logic        level;
  logic [7:0]  deb_dec;
  logic [23:0] elapsed_inc;
  logic [15:0] low_inc;
  logic [7:0]  top_inc;
  logic [24:0] sum;
  logic        status_hit, scan_hit, frame_now;
  logic [1:0]  ser_n;
  logic [7:0]  ser0, ser1;
  logic [FRAME_BYTES-1:0][7:0] frame_b;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = ~fifo_full_i;
  assign accept      = in_i.valid & ~fifo_full_i;
  assign level       = ~in_i.pin_raw;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q <= DEBOUNCE_RST;
      status_rq_q <= STATUS_RQ_RST;
      status_rp_q <= STATUS_RP_RST;
      header_q    <= HEADER_RST;
      scan_q      <= SCAN_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_DEBOUNCE_TICKS: deb_ticks_q <= cfg_i.data;
        REG_STATUS_RQ:      status_rq_q <= cfg_i.data;
        REG_STATUS_RP:      status_rp_q <= cfg_i.data;
        REG_HEADER:         header_q    <= cfg_i.data;
        REG_SCAN:           scan_q      <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Debounce tick, then chrono tick: low half wraps, top byte saturates
  always_comb begin
    deb_dec = (in_i.debounce_tick && deb_left_q != 8'd0) ? deb_left_q - 8'd1 : deb_left_q;
    low_inc = elapsed_q[15:0] + 16'd1;
    top_inc = elapsed_q[23:16];
    if (low_inc == 16'd0 && top_inc != TOP_SAT) begin
      top_inc = top_inc + 8'd1;
    end
    elapsed_inc = in_i.chrono_tick ? {top_inc, low_inc} : elapsed_q;
    sum = {1'b0, elapsed_inc} + {1'b0, stamp_q};
  end

  // Phase automaton
  always_comb begin
    phase_d    = phase_q;
    elapsed_d  = elapsed_inc;
    stamp_d    = stamp_q;
    deb_left_d = deb_dec;
    stable_d   = stable_q;
    first_d    = first_q;
    frame_now  = 1'b0;
    unique case (phase_q)
      PH_DEBOUNCE: begin
        if (deb_dec == 8'd0) begin
          if (level == stable_q) begin
            // spurious pulse: give the consumed time back
            elapsed_d = sum[24] ? COUNT_SAT : sum[23:0];
            phase_d   = PH_WAIT;
          end else begin
            stable_d = level;
            phase_d  = PH_FRAME;
          end
        end
      end
      PH_FRAME: begin
        frame_now = 1'b1;
        phase_d   = PH_WAIT;
      end
      default: begin
        phase_d = PH_WAIT;
        if (level != stable_q) begin
          stamp_d    = first_q ? 24'd0 : elapsed_inc;
          elapsed_d  = 24'd0;
          deb_left_d = deb_ticks_q;
          first_d    = 1'b0;
          phase_d    = PH_DEBOUNCE;
        end
      end
    endcase
  end

  // Serial service and job assembly: reply bytes first, then the frame
  always_comb begin
    status_hit = in_i.rx_valid && in_i.rx_byte == status_rq_q;
    scan_hit   = in_i.rx_valid && !status_hit && in_i.rx_byte == scan_q;
    ser_n      = status_hit ? 2'd2 : (scan_hit ? 2'd1 : 2'd0);
    ser0       = status_hit ? status_rp_q : scan_q;
    ser1       = {7'd0, stable_q};
    frame_b[0] = header_q;
    frame_b[1] = {7'd0, stable_q};
    frame_b[2] = stamp_q[23:16];
    frame_b[3] = stamp_q[15:8];
    frame_b[4] = stamp_q[7:0];
    job_o.bytes = '0;
    case (ser_n)
      2'd2: begin
        job_o.bytes[0]   = ser0;
        job_o.bytes[1]   = ser1;
        job_o.bytes[6:2] = frame_b;
      end
      2'd1: begin
        job_o.bytes[0]   = ser0;
        job_o.bytes[5:1] = frame_b;
      end
      default: begin
        job_o.bytes[4:0] = frame_b;
      end
    endcase
    job_o.count = CNT_W'(ser_n) + (frame_now ? CNT_W'(FRAME_BYTES) : CNT_W'(0));
    job_o.led   = (phase_d == PH_FRAME) ? stable_d : ~stable_d;
    push_o      = accept && job_o.count != '0;
  end

  // Hold state until an item is accepted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT;
      elapsed_q  <= '0;
      stamp_q    <= '0;
      deb_left_q <= DEBOUNCE_RST;
      stable_q   <= 1'b0;
      first_q    <= 1'b1;
    end else if (accept) begin
      phase_q    <= phase_d;
      elapsed_q  <= elapsed_d;
      stamp_q    <= stamp_d;
      deb_left_q <= deb_left_d;
      stable_q   <= stable_d;
      first_q    <= first_d;
    end
  end

endmodule

`default_nettype wire

[rtl/det_fifo.sv]
// Job queue between front and back end.
// Depends on det_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module det_fifo import det_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  input  wire logic pop_i,
  output job_t      head_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/det_back.sv]
// Back end: serializes the head job into result bytes through an output register.
// Depends on det_pkg and det_if; reads det_fifo.
`timescale 1ns / 1ps
`default_nettype none

module det_back import det_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire job_t  head_i,
  input  wire logic  empty_i,
  output logic       pop_o,
  det_out_if.source  out_o
);

  logic [IDX_W-1:0] idx_q;
  logic             valid_q;
  logic [7:0]       byte_q;
  logic             last_q, led_q;
  logic             load, is_last;

  assign load    = !empty_i && (!valid_q || out_o.ready);
  assign is_last = (CNT_W'(idx_q) + CNT_W'(1)) == head_i.count;
  assign pop_o   = load && is_last;

  assign out_o.valid   = valid_q;
  assign out_o.tx_byte = byte_q;
  assign out_o.tx_last = last_q;
  assign out_o.led_on  = led_q;

  // Step through the head job one byte per load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= is_last ? '0 : idx_q + IDX_W'(1);
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.bytes[idx_q];
      last_q <= is_last;
      led_q  <= head_i.led;
    end
  end

endmodule

`default_nettype wire

[rtl/debounced_edge_timestamper.sv]
// Top level of the debounced edge timestamper: front end, job queue, back end.
// Depends on det_pkg, det_if, det_front, det_fifo and det_back.
//
//   channel   dir   carries                                        accepted when
//   in_i      in    pin_raw, chrono_tick, debounce_tick, rx_*      valid & ready
//   out_o     out   tx_byte, tx_last, led_on                       valid & ready
//   cfg_i     in    index (register number), data                  valid & ready
//
// The front end takes one item per cycle while the job queue has room, updating
// all state in the cycle of acceptance. The back end sends one byte per cycle while
// out_o is ready; an item causes at most 7 bytes, and the queue (QueueDepth jobs)
// absorbs bursts. Reset clears control state only; no clearing pass.
// Configuration writes are always ready.
`timescale 1ns / 1ps
`default_nettype none

module debounced_edge_timestamper import det_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  det_in_if.sink    in_i,
  det_cfg_if.sink   cfg_i,
  det_out_if.source out_o
);

  job_t job, head;
  logic job_push, job_pop, fifo_full, fifo_empty;

  det_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .fifo_full_i (fifo_full),
    .job_o       (job),
    .push_o      (job_push)
  );

  det_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job),
    .pop_i   (job_pop),
    .head_o  (head),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  det_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (fifo_empty),
    .pop_o   (job_pop),
    .out_o   (out_o)
  );

`ifndef ASSERT_OFF
  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_push |-> !fifo_full)
    else $error("job pushed into full queue");

  // Never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_pop |-> !fifo_empty)
    else $error("job popped from empty queue");

  // A queued job always carries at least one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !fifo_empty |-> (head.count != '0))
    else $error("empty job at queue head");

  // Popping a job presents its last byte on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   job_pop |=> (out_o.valid && out_o.tx_last))
    else $error("job retired without last byte");
`endif

endmodule

`default_nettype wire

[tb/sv/debounced_edge_timestamper_tb.sv]
// Self-checking bench for debounced_edge_timestamper: a plan of time steps and
// register writes drives the block while a predictor forecasts every reply byte.
// Depends on det_pkg, det_if and the timestamper RTL.
`timescale 1ns / 1ps

module debounced_edge_timestamper_tb;
  import det_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PRINT_CAP     = 100;

  typedef enum logic [1:0] {
    PLAN_STEP,
    PLAN_WRITE,
    PLAN_IDLING
  } plan_kind_e;

  // One entry of the stimulus plan: a time step, a register write or an idling change
  typedef struct {
    plan_kind_e  kind;
    logic        pin_raw;
    logic        chrono_tick;
    logic        debounce_tick;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    cfg_reg_e    cfg_sel;
    logic [7:0]  cfg_data;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
  } plan_t;

  typedef struct {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       led_on;
  } tx_expect_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  det_in_if  in_if ();
  det_cfg_if cfg_if ();
  det_out_if out_if ();

  debounced_edge_timestamper DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  plan_t       step_plan[$];
  tx_expect_t  awaited_bytes[$];
  int unsigned mismatches     = 0;
  int unsigned planned_steps  = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned settle_count   = 0;
  logic        in_fire        = 1'b0;
  logic        cfg_fire       = 1'b0;

  // Register copies kept by the predictor
  logic [7:0] shadow_deb  = DEBOUNCE_RST;
  logic [7:0] shadow_rq   = STATUS_RQ_RST;
  logic [7:0] shadow_rp   = STATUS_RP_RST;
  logic [7:0] shadow_hdr  = HEADER_RST;
  logic [7:0] shadow_scan = SCAN_RST;

  // Predicted block state
  phase_e      pred_phase         = PH_WAIT;
  logic [23:0] pred_elapsed       = '0;
  logic [23:0] pred_stamp         = '0;
  logic [7:0]  pred_debounce_left = DEBOUNCE_RST;
  logic        pred_level         = 1'b0;
  logic        pred_first         = 1'b1;

  // Register values the stimulus generator aims at
  logic [7:0] gen_deb  = DEBOUNCE_RST;
  logic [7:0] gen_rq   = STATUS_RQ_RST;
  logic [7:0] gen_scan = SCAN_RST;
  logic       gen_pin  = 1'b1;

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  // Advance the predicted state by one time step and queue the bytes it causes
  function automatic void advance_timestamper(logic pin, logic chrono, logic dtick,
                                              logic rxv, logic [7:0] rxb);
    logic       level;
    logic [15:0] low;
    logic [7:0]  top;
    logic [24:0] sum;
    logic [7:0]  burst[$];
    logic        led;
    tx_expect_t  e;
    level = !pin;
    if (dtick && pred_debounce_left != 8'd0)
      pred_debounce_left--;
    // Low half wraps, top byte saturates
    if (chrono) begin
      low = pred_elapsed[15:0] + 16'd1;
      top = pred_elapsed[23:16];
      if (low == 16'd0 && top != TOP_SAT)
        top++;
      pred_elapsed = {top, low};
    end
    // Serial service; a status request wins over a scan echo
    if (rxv) begin
      if (rxb == shadow_rq) begin
        burst.push_back(shadow_rp);
        burst.push_back({7'd0, pred_level});
      end else if (rxb == shadow_scan) begin
        burst.push_back(shadow_scan);
      end
    end
    case (pred_phase)
      PH_DEBOUNCE: begin
        if (pred_debounce_left == 8'd0) begin
          if (level == pred_level) begin
            // Spurious pulse: give the consumed time back
            sum = {1'b0, pred_elapsed} + {1'b0, pred_stamp};
            pred_elapsed = sum[24] ? COUNT_SAT : sum[23:0];
            pred_phase = PH_WAIT;
          end else begin
            pred_level = level;
            pred_phase = PH_FRAME;
          end
        end
      end
      PH_FRAME: begin
        burst.push_back(shadow_hdr);
        burst.push_back({7'd0, pred_level});
        burst.push_back(pred_stamp[23:16]);
        burst.push_back(pred_stamp[15:8]);
        burst.push_back(pred_stamp[7:0]);
        pred_phase = PH_WAIT;
      end
      default: begin
        pred_phase = PH_WAIT;
        if (level != pred_level) begin
          if (pred_first) begin
            pred_elapsed = '0;
            pred_first = 1'b0;
          end
          pred_stamp = pred_elapsed;
          pred_elapsed = '0;
          pred_debounce_left = shadow_deb;
          pred_phase = PH_DEBOUNCE;
        end
      end
    endcase
    // LED lags until the frame has gone out
    led = (pred_phase == PH_FRAME) ? pred_level : !pred_level;
    foreach (burst[k]) begin
      e.tx_byte = burst[k];
      e.tx_last = (k == burst.size() - 1);
      e.led_on  = led;
      awaited_bytes.push_back(e);
    end
  endfunction

  function automatic void plan_step(logic pin, logic chrono, logic dtick, logic rxv,
                                    logic [7:0] rxb);
    plan_t p;
    p.kind          = PLAN_STEP;
    p.pin_raw       = pin;
    p.chrono_tick   = chrono;
    p.debounce_tick = dtick;
    p.rx_valid      = rxv;
    p.rx_byte       = rxb;
    step_plan.push_back(p);
    planned_steps++;
  endfunction

  function automatic void plan_write(cfg_reg_e sel, logic [7:0] data);
    plan_t p;
    p.kind     = PLAN_WRITE;
    p.cfg_sel  = sel;
    p.cfg_data = data;
    step_plan.push_back(p);
    case (sel)
      REG_DEBOUNCE_TICKS: gen_deb = data;
      REG_STATUS_RQ:      gen_rq = data;
      REG_SCAN:           gen_scan = data;
      default: ;
    endcase
  endfunction

  function automatic void plan_idling(int unsigned send_pct, int unsigned recv_pct);
    plan_t p;
    p.kind           = PLAN_IDLING;
    p.send_idle_pct  = send_pct;
    p.recv_stall_pct = recv_pct;
    step_plan.push_back(p);
  endfunction

  // Random content, mostly debounce ticks, serial bytes aimed at the live codes
  function automatic void plan_random_step(logic pin);
    int unsigned pick;
    logic [7:0]  rxb;
    pick = $urandom_range(0, 9);
    if (pick < 4)
      rxb = gen_rq;
    else if (pick < 7)
      rxb = gen_scan;
    else
      rxb = 8'($urandom_range(0, 255));
    plan_step(pin, 1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0,
              $urandom_range(0, 2) == 0, rxb);
  endfunction

  // One pin episode: a real change, a short bounce, or quiet steps
  function automatic void plan_burst();
    int unsigned pick;
    int unsigned hold;
    pick = $urandom_range(0, 9);
    hold = gen_deb + 2 + $urandom_range(0, 2);
    if (pick < 5) begin
      gen_pin = !gen_pin;
      for (int k = 0; k < hold; k++)
        plan_random_step(gen_pin);
    end else if (pick < 8) begin
      for (int k = 0; k <= $urandom_range(0, 1); k++)
        plan_random_step(!gen_pin);
      for (int k = 0; k < hold; k++)
        plan_random_step(gen_pin);
    end else begin
      for (int k = 0; k <= $urandom_range(0, 2); k++)
        plan_random_step(gen_pin);
    end
  endfunction

  // Driver: present the next planned request at the falling edge
  always @(negedge clk_i) begin
    plan_t head;
    logic  drive_step;
    logic  drive_write;
    drive_step  = 1'b0;
    drive_write = 1'b0;
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_ni && !(in_if.valid && !in_fire) && !(cfg_if.valid && !cfg_fire)) begin
      while (step_plan.size() != 0 && step_plan[0].kind == PLAN_IDLING) begin
        send_idle_pct  = step_plan[0].send_idle_pct;
        recv_stall_pct = step_plan[0].recv_stall_pct;
        step_plan.delete(0);
      end
      if (step_plan.size() != 0) begin
        head = step_plan[0];
        if (head.kind == PLAN_WRITE) begin
          // Hold writes until the block has drained and settled
          if (awaited_bytes.size() != 0) begin
            settle_count = 0;
          end else if (settle_count < SETTLE_CYCLES) begin
            settle_count++;
          end else begin
            drive_write = 1'b1;
            settle_count = 0;
            cfg_if.index <= head.cfg_sel;
            cfg_if.data  <= head.cfg_data;
            step_plan.delete(0);
          end
        end else if ($urandom_range(0, 99) >= send_idle_pct) begin
          drive_step = 1'b1;
          in_if.pin_raw       <= head.pin_raw;
          in_if.chrono_tick   <= head.chrono_tick;
          in_if.debounce_tick <= head.debounce_tick;
          in_if.rx_valid      <= head.rx_valid;
          in_if.rx_byte       <= head.rx_byte;
          step_plan.delete(0);
        end
      end
      in_if.valid  <= drive_step;
      cfg_if.valid <= drive_write;
    end
  end

  // Monitor: check reply bytes, track register writes, predict accepted steps
  always @(posedge clk_i) begin
    tx_expect_t want;
    in_fire  <= rst_ni && in_if.valid && in_if.ready;
    cfg_fire <= rst_ni && cfg_if.valid && cfg_if.ready;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (awaited_bytes.size() == 0) begin
          report_mismatch("byte with nothing awaited", 8'hxx, out_if.tx_byte);
        end else begin
          want = awaited_bytes.pop_front();
          if (out_if.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", want.tx_byte, out_if.tx_byte);
          if (out_if.tx_last !== want.tx_last)
            report_mismatch("tx_last", {7'd0, want.tx_last}, {7'd0, out_if.tx_last});
          if (out_if.led_on !== want.led_on)
            report_mismatch("led_on", {7'd0, want.led_on}, {7'd0, out_if.led_on});
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_DEBOUNCE_TICKS: shadow_deb = cfg_if.data;
          REG_STATUS_RQ:      shadow_rq = cfg_if.data;
          REG_STATUS_RP:      shadow_rp = cfg_if.data;
          REG_HEADER:         shadow_hdr = cfg_if.data;
          REG_SCAN:           shadow_scan = cfg_if.data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready)
        advance_timestamper(in_if.pin_raw, in_if.chrono_tick, in_if.debounce_tick,
                            in_if.rx_valid, in_if.rx_byte);
    end
  end

  initial begin
    int unsigned goal;
    in_if.valid         = 1'b0;
    in_if.pin_raw       = 1'b1;
    in_if.chrono_tick   = 1'b0;
    in_if.debounce_tick = 1'b0;
    in_if.rx_valid      = 1'b0;
    in_if.rx_byte       = 8'h00;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_DEBOUNCE_TICKS;
    cfg_if.data         = 8'h00;
    out_if.ready        = 1'b0;

    // Directed: reset codes, serial service, first press, frame with reply, bounce
    plan_idling(0, 0);
    plan_step(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
    plan_step(1'b1, 1'b0, 1'b0, 1'b1, STATUS_RQ_RST);
    plan_step(1'b1, 1'b0, 1'b0, 1'b1, SCAN_RST);
    plan_step(1'b1, 1'b0, 1'b0, 1'b1, 8'h00);
    plan_step(1'b1, 1'b1, 1'b0, 1'b0, 8'hFF);
    plan_step(1'b1, 1'b1, 1'b1, 1'b0, 8'h00);
    // First press stamps zero
    plan_step(1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
    for (int k = 0; k < 5; k++)
      plan_step(1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
    // Status reply and change frame in one step
    plan_step(1'b0, 1'b0, 1'b0, 1'b1, STATUS_RQ_RST);
    plan_step(1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
    plan_step(1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
    // Short release that bounces back: time is added back
    plan_step(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
    for (int k = 0; k < 5; k++)
      plan_step(1'b0, 1'b1, 1'b1, k == 2, SCAN_RST);

    // Zero debounce, status and scan codes equal
    plan_write(REG_DEBOUNCE_TICKS, 8'h00);
    plan_write(REG_STATUS_RQ, 8'h00);
    plan_write(REG_STATUS_RP, 8'hFF);
    plan_write(REG_HEADER, 8'h00);
    plan_write(REG_SCAN, 8'h00);
    plan_step(1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
    plan_step(1'b1, 1'b1, 1'b0, 1'b0, 8'h00);
    plan_step(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
    plan_step(1'b1, 1'b0, 1'b0, 1'b1, 8'h00);
    plan_step(1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
    plan_step(1'b1, 1'b0, 1'b0, 1'b1, 8'hFF);

    // Top register values but scan code 01; pin stays put so no long debounce starts
    plan_write(REG_DEBOUNCE_TICKS, 8'hFF);
    plan_write(REG_STATUS_RQ, 8'hFF);
    plan_write(REG_STATUS_RP, 8'h00);
    plan_write(REG_HEADER, 8'hFF);
    plan_write(REG_SCAN, 8'h01);
    plan_step(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
    plan_step(1'b1, 1'b0, 1'b1, 1'b1, 8'h01);
    gen_pin = 1'b1;

    // Random episodes under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       plan_idling(0, 0);
        1:       plan_idling(79, 0);
        2:       plan_idling(0, 79);
        default: plan_idling(7, 7);
      endcase
      plan_write(REG_DEBOUNCE_TICKS, 8'($urandom_range(0, 4)));
      plan_write(REG_STATUS_RQ, 8'($urandom_range(0, 255)));
      plan_write(REG_STATUS_RP, 8'($urandom_range(0, 255)));
      plan_write(REG_HEADER, 8'($urandom_range(0, 255)));
      plan_write(REG_SCAN, ($urandom_range(0, 3) == 0) ? gen_rq : 8'($urandom_range(0, 255)));
      goal = planned_steps + 28;
      while (planned_steps < goal)
        plan_burst();
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: everything sent, every byte seen, then let the block settle
    while (step_plan.size() != 0 || in_if.valid || cfg_if.valid || awaited_bytes.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
rtl/det_pkg.sv
rtl/det_if.sv
rtl/det_front.sv
rtl/det_fifo.sv
rtl/det_back.sv
rtl/debounced_edge_timestamper.sv
tb/sv/debounced_edge_timestamper_tb.sv
